// File: sv/alrle_pkg.sv
// Shared types, constants and helpers of the audio level run-length encoder.
package alrle_pkg;

    // Level scale: level = trunc(sample * 127 / 32765) + 128
    localparam int unsigned PROD_W    = 22;
    localparam int unsigned QUO_W     = 7;
    localparam logic [PROD_W-1:0] SCALE_DIV = 22'd32765;
    localparam logic [7:0]  LEVEL_MID       = 8'd128;
    localparam logic [7:0]  RUN_LIMIT_RESET = 8'd255;
    localparam logic [15:0] RUN_COUNT_MAX   = 16'hFFFF;
    localparam logic [31:0] PAIR_TOTAL_MAX  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]  run_length;
        logic [7:0]  level;
        logic [15:0] longest_run;
        logic [31:0] pairs_emitted;
    } pair_t;

    // All results caused by one sample: one or two pairs
    typedef struct packed {
        logic        two_pairs;
        logic [7:0]  max_level;
        logic [7:0]  min_level;
        pair_t       first;
        pair_t       second;
    } burst_t;

    typedef struct packed {
        logic   empty;
        burst_t head;
    } queue_status_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] x);
        sat_inc32 = (x == PAIR_TOTAL_MAX) ? x : x + 32'd1;
    endfunction

endpackage

// File: sv/alrle_in_if.sv
// Sample channel: valid/ready handshake with sample and last-sample flag.
interface alrle_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last_sample;

    modport source (output valid, sample, last_sample, input ready);
    modport sink   (input valid, sample, last_sample, output ready);
endinterface

// File: sv/alrle_out_if.sv
// Pair channel: valid/ready handshake with one run-length pair and statistics.
interface alrle_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  run_length;
    logic [7:0]  level;
    logic [7:0]  max_level;
    logic [7:0]  min_level;
    logic [15:0] longest_run;
    logic [31:0] pairs_emitted;
    logic        end_of_burst;

    modport source (output valid, run_length, level, max_level, min_level, longest_run,
                    pairs_emitted, end_of_burst, input ready);
    modport sink   (input valid, run_length, level, max_level, min_level, longest_run,
                    pairs_emitted, end_of_burst, output ready);
    modport monitor (input valid, ready, run_length, level, max_level, min_level,
                     longest_run, pairs_emitted, end_of_burst);
endinterface

// File: sv/audio_level_run_length_encoder_unit.sv
// Top level of the audio level run-length encoder.
//
//  channel   direction  beat                               accepted when
//  samples   in         sample, last_sample                valid && ready
//  pairs     out        run_length, level, stats, end flag valid && ready
//  cfg       in         max_run_length (cfg_wr_data)       cfg_wr_en
//
// One sample per cycle while the burst queue is not full; a sample causing two pairs
// takes two output beats. A sample beat passes the scale stage, the level/run stage
// into the burst queue and the output register before its pair beat.
// Reset clears runs and statistics and sets max_run_length to 255.
// The burst queue (QUEUE_DEPTH bursts) lets input and output stall on their own.
module audio_level_run_length_encoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    alrle_in_if.sink    samples,
    alrle_out_if.source pairs
);
    import alrle_pkg::*;

    burst_t        burst;
    logic          push;
    logic          full;
    logic          pop;
    queue_status_t status;

    alrle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (samples),
        .full        (full),
        .push        (push),
        .burst       (burst)
    );

    alrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (burst),
        .full    (full),
        .pop     (pop),
        .status  (status)
    );

    alrle_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .pop    (pop),
        .pairs  (pairs)
    );

endmodule

// File: sv/alrle_front.sv
// Front end: scales samples to levels, tracks runs and statistics, builds bursts.
module alrle_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [7:0]      cfg_wr_data,
    alrle_in_if.sink        samples,
    input  logic            full,
    output logic            push,
    output alrle_pkg::burst_t burst
);
    import alrle_pkg::*;

    logic              s1_valid_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              neg_reg;
    logic              last_reg;

    logic [7:0]  max_run_length_reg;
    logic [7:0]  current_level_reg;
    logic        run_active_reg;
    logic [7:0]  chunk_count_reg;
    logic [15:0] whole_run_count_reg;
    logic [7:0]  max_seen_reg;
    logic [7:0]  min_seen_reg;
    logic [15:0] longest_seen_reg;
    logic [31:0] pair_total_reg;

    logic [7:0]  current_level_next;
    logic        run_active_next;
    logic [7:0]  chunk_count_next;
    logic [15:0] whole_run_count_next;
    logic [7:0]  max_seen_next;
    logic [7:0]  min_seen_next;
    logic [15:0] longest_seen_next;
    logic [31:0] pair_total_next;

    logic              accept;
    logic              advance;
    logic [16:0]       mag;
    logic [23:0]       prod_w;
    logic [QUO_W-1:0]  quo_est;
    logic [PROD_W-1:0] bound;
    logic [7:0]        quo;
    logic [7:0]        lvl;
    logic [7:0]        limit;
    logic [1:0]        n_pairs;

    assign advance       = s1_valid_reg && !full;
    assign samples.ready = !s1_valid_reg || advance;
    assign accept        = samples.valid && samples.ready;

    // Stage 1: magnitude times 127 as shift and subtract
    assign mag    = samples.sample[15] ? (17'd0 - {1'b1, samples.sample})
                                       : {1'b0, samples.sample};
    assign prod_w = {7'd0, mag[16:0]} << 7;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg <= PROD_W'(prod_w - {7'd0, mag});
            neg_reg  <= samples.sample[15];
            last_reg <= samples.last_sample;
        end
    end

    // Stage 2: dividing by 32768 undershoots the quotient by at most one; fix it up
    assign quo_est = prod_reg[PROD_W-1:PROD_W-QUO_W];
    assign bound   = PROD_W'((32'(quo_est) + 32'd1) * 32'(SCALE_DIV));
    assign quo     = {1'b0, quo_est} + ((prod_reg >= bound) ? 8'd1 : 8'd0);
    assign lvl     = neg_reg ? (LEVEL_MID - quo) : (LEVEL_MID + quo);
    assign limit   = (max_run_length_reg == 8'd0) ? 8'd1 : max_run_length_reg;

    always_comb
    begin
        pair_t p;
        p                    = '0;
        n_pairs              = 2'd0;
        burst                = '0;
        current_level_next   = current_level_reg;
        run_active_next      = run_active_reg;
        chunk_count_next     = chunk_count_reg;
        whole_run_count_next = whole_run_count_reg;
        longest_seen_next    = longest_seen_reg;
        pair_total_next      = pair_total_reg;
        max_seen_next        = (lvl > max_seen_reg) ? lvl : max_seen_reg;
        min_seen_next        = (lvl < min_seen_reg) ? lvl : min_seen_reg;

        // Level change: close the old run and send what is pending of it
        if (run_active_next && (lvl != current_level_next))
        begin
            if (whole_run_count_next > longest_seen_next)
            begin
                longest_seen_next = whole_run_count_next;
            end
            if (chunk_count_next != 8'd0)
            begin
                pair_total_next = sat_inc32(pair_total_next);
                p = '{chunk_count_next, current_level_next, longest_seen_next,
                      pair_total_next};
                burst.first = p;
                n_pairs     = 2'd1;
            end
            run_active_next = 1'b0;
        end

        if (!run_active_next)
        begin
            run_active_next      = 1'b1;
            current_level_next   = lvl;
            chunk_count_next     = 8'd1;
            whole_run_count_next = 16'd1;
        end
        else
        begin
            chunk_count_next = chunk_count_next + 8'd1;
            if (whole_run_count_next < RUN_COUNT_MAX)
            begin
                whole_run_count_next = whole_run_count_next + 16'd1;
            end
        end

        // Full chunk: split the run
        if (chunk_count_next >= limit)
        begin
            pair_total_next = sat_inc32(pair_total_next);
            p = '{chunk_count_next, current_level_next, longest_seen_next, pair_total_next};
            if (n_pairs == 2'd0)
            begin
                burst.first = p;
            end
            else
            begin
                burst.second = p;
            end
            n_pairs          = n_pairs + 2'd1;
            chunk_count_next = 8'd0;
        end

        // Last sample: flush
        if (last_reg)
        begin
            if (whole_run_count_next > longest_seen_next)
            begin
                longest_seen_next = whole_run_count_next;
            end
            if (chunk_count_next != 8'd0)
            begin
                pair_total_next = sat_inc32(pair_total_next);
                p = '{chunk_count_next, current_level_next, longest_seen_next,
                      pair_total_next};
                if (n_pairs == 2'd0)
                begin
                    burst.first = p;
                end
                else
                begin
                    burst.second = p;
                end
                n_pairs = n_pairs + 2'd1;
            end
            run_active_next      = 1'b0;
            chunk_count_next     = 8'd0;
            whole_run_count_next = 16'd0;
        end

        burst.two_pairs = (n_pairs == 2'd2);
        burst.max_level = max_seen_next;
        burst.min_level = min_seen_next;
    end

    assign push = advance && (n_pairs != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_run_length_reg  <= RUN_LIMIT_RESET;
            current_level_reg   <= 8'd0;
            run_active_reg      <= 1'b0;
            chunk_count_reg     <= 8'd0;
            whole_run_count_reg <= 16'd0;
            max_seen_reg        <= 8'd0;
            min_seen_reg        <= 8'd255;
            longest_seen_reg    <= 16'd0;
            pair_total_reg      <= 32'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_run_length_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                current_level_reg   <= current_level_next;
                run_active_reg      <= run_active_next;
                chunk_count_reg     <= chunk_count_next;
                whole_run_count_reg <= whole_run_count_next;
                max_seen_reg        <= max_seen_next;
                min_seen_reg        <= min_seen_next;
                longest_seen_reg    <= longest_seen_next;
                pair_total_reg      <= pair_total_next;
            end
        end
    end

endmodule

// File: sv/alrle_queue.sv
// Burst queue between front and back end.
module alrle_queue #(
    parameter int DEPTH = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  alrle_pkg::burst_t         wr_data,
    output logic                      full,
    input  logic                      pop,
    output alrle_pkg::queue_status_t  status
);
    import alrle_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    burst_t           store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full         = (count_reg == DEPTH_CNT);
    assign status.empty = (count_reg == '0);
    assign status.head  = store[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/alrle_back.sv
// Back end: unpacks bursts into pair beats through an output register.
module alrle_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  alrle_pkg::queue_status_t status,
    output logic                     pop,
    alrle_out_if.source              pairs
);
    import alrle_pkg::*;

    logic       valid_reg;
    logic       sel_reg;
    logic       load;
    logic       take_last;
    pair_t      pair_reg;
    logic [7:0] max_reg;
    logic [7:0] min_reg;
    logic       end_reg;

    assign load      = !valid_reg || pairs.ready;
    // The head is done after its second pair, or after its first when it has one
    assign take_last = sel_reg || !status.head.two_pairs;
    assign pop       = load && !status.empty && take_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= !status.empty;
            if (!status.empty)
            begin
                sel_reg <= !take_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !status.empty)
        begin
            pair_reg <= sel_reg ? status.head.second : status.head.first;
            max_reg  <= status.head.max_level;
            min_reg  <= status.head.min_level;
            end_reg  <= take_last;
        end
    end

    assign pairs.valid         = valid_reg;
    assign pairs.run_length    = pair_reg.run_length;
    assign pairs.level         = pair_reg.level;
    assign pairs.max_level     = max_reg;
    assign pairs.min_level     = min_reg;
    assign pairs.longest_run   = pair_reg.longest_run;
    assign pairs.pairs_emitted = pair_reg.pairs_emitted;
    assign pairs.end_of_burst  = end_reg;

endmodule

// File: sv/alrle_checker.sv
// Port-level checks of the pair channel, bound to the top level.
module alrle_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [7:0]  run_length,
    input logic [7:0]  level,
    input logic [7:0]  max_level,
    input logic [7:0]  min_level,
    input logic [31:0] pairs_emitted
);

    // Hold a stalled beat
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("pair beat dropped while stalled");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (run_length != 8'd0) && (level != 8'd0))
        else $error("empty run or zero level in a pair");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (min_level <= max_level)
                  && (min_level <= level)
                  && (level <= max_level))
        else $error("level statistics out of order");

    // Advance the pair total by one per beat, or hold it at saturation
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready ##1 valid |->
            ({1'b0, pairs_emitted} == {1'b0, $past(pairs_emitted)} + 33'd1)
            || ((pairs_emitted == 32'hFFFF_FFFF)
                && ($past(pairs_emitted) == 32'hFFFF_FFFF)))
        else $error("pair total did not advance by one");

endmodule

bind audio_level_run_length_encoder_unit alrle_checker u_alrle_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (pairs.valid),
    .ready         (pairs.ready),
    .run_length    (pairs.run_length),
    .level         (pairs.level),
    .max_level     (pairs.max_level),
    .min_level     (pairs.min_level),
    .pairs_emitted (pairs.pairs_emitted)
);

// File: bench/alrle_pair_checker.sv
`timescale 1ns / 1ps
// Pair checker: watches both channels, predicts the run-length pairs and compares every beat.
module alrle_pair_checker
    import alrle_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    alrle_in_if                samples,
    alrle_out_if.monitor       pairs,
    output int unsigned        fail_count,
    output int unsigned        pending_pairs,
    output int unsigned        samples_seen,
    output int unsigned        pairs_seen
);

    localparam int LEVEL_SCALE_NUM = 127;
    localparam int LEVEL_SCALE_DEN = 32765;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [7:0]  run_length;
        logic [7:0]  level;
        logic [7:0]  max_level;
        logic [7:0]  min_level;
        logic [15:0] longest_run;
        logic [31:0] pairs_emitted;
        logic        end_of_burst;
    } pair_beat_t;

    pair_beat_t  expected_pairs[$];
    pair_beat_t  got;
    pair_beat_t  want;

    // Encoder state as the block should hold it
    logic [7:0]  run_limit;
    logic [7:0]  cur_level;
    logic        run_open;
    logic [7:0]  chunk_len;
    logic [15:0] run_len;
    logic [7:0]  level_max;
    logic [7:0]  level_min;
    logic [15:0] longest;
    logic [31:0] pair_count;

    int unsigned errors;
    int unsigned beats_in;
    int unsigned beats_out;

    function automatic void close_run();
        if (run_len > longest)
            longest = run_len;
    endfunction

    function automatic void emit_pair();
        pair_beat_t p;
        if (pair_count != PAIR_TOTAL_MAX)
            pair_count++;
        p.run_length    = chunk_len;
        p.level         = cur_level;
        p.max_level     = level_max;
        p.min_level     = level_min;
        p.longest_run   = longest;
        p.pairs_emitted = pair_count;
        p.end_of_burst  = 1'b0;
        expected_pairs.push_back(p);
        chunk_len = '0;
    endfunction

    function automatic void predict_pairs(input logic signed [15:0] smp, input logic lst);
        int         s;
        int         q;
        logic [7:0] lvl;
        logic [7:0] limit;
        int         n_before;
        s        = int'(smp);
        q        = (s * LEVEL_SCALE_NUM) / LEVEL_SCALE_DEN;
        lvl      = 8'(q + int'(LEVEL_MID));
        limit    = (run_limit == 8'd0) ? 8'd1 : run_limit;
        n_before = expected_pairs.size();

        if (lvl > level_max)
            level_max = lvl;
        if (lvl < level_min)
            level_min = lvl;

        // A level change closes the old run; a chunk emptied by a split sends nothing
        if (run_open && lvl != cur_level)
        begin
            close_run();
            if (chunk_len != 8'd0)
                emit_pair();
            run_open = 1'b0;
        end

        if (!run_open)
        begin
            run_open  = 1'b1;
            cur_level = lvl;
            chunk_len = 8'd1;
            run_len   = 16'd1;
        end
        else
        begin
            chunk_len++;
            if (run_len != RUN_COUNT_MAX)
                run_len++;
        end

        if (chunk_len >= limit)
            emit_pair();

        if (lst)
        begin
            close_run();
            if (chunk_len != 8'd0)
                emit_pair();
            run_open  = 1'b0;
            chunk_len = '0;
            run_len   = '0;
        end

        if (expected_pairs.size() > n_before)
            expected_pairs[expected_pairs.size() - 1].end_of_burst = 1'b1;
    endfunction

    function automatic string describe(input pair_beat_t p);
        return $sformatf("len %0d level %0d max %0d min %0d longest %0d count %0d end %0b",
                         p.run_length, p.level, p.max_level, p.min_level, p.longest_run,
                         p.pairs_emitted, p.end_of_burst);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pairs.delete();
            run_limit     = RUN_LIMIT_RESET;
            cur_level     = '0;
            run_open      = 1'b0;
            chunk_len     = '0;
            run_len       = '0;
            level_max     = '0;
            level_min     = 8'd255;
            longest       = '0;
            pair_count    = '0;
            errors        = 0;
            beats_in      = 0;
            beats_out     = 0;
            fail_count    <= 0;
            pending_pairs <= 0;
            samples_seen  <= 0;
            pairs_seen    <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                run_limit = cfg_wr_data;

            if (samples.valid && samples.ready)
            begin
                beats_in++;
                predict_pairs(samples.sample, samples.last_sample);
            end

            if (pairs.valid && pairs.ready)
            begin
                beats_out++;
                got.run_length    = pairs.run_length;
                got.level         = pairs.level;
                got.max_level     = pairs.max_level;
                got.min_level     = pairs.min_level;
                got.longest_run   = pairs.longest_run;
                got.pairs_emitted = pairs.pairs_emitted;
                got.end_of_burst  = pairs.end_of_burst;
                if (expected_pairs.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("pair %0d unexpected: %s", beats_out, describe(got));
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                        begin
                            $display("pair %0d mismatch", beats_out);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(got));
                        end
                    end
                end
            end

            fail_count    <= errors;
            pending_pairs <= expected_pairs.size();
            samples_seen  <= beats_in;
            pairs_seen    <= beats_out;
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: drives samples, config and backpressure for the run-length encoder.
module tb_top;

    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BLOCK_ITEMS    = 25;
    localparam int LONG_RUN_ITEMS = 260;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;

    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_rx;
    logic        hold_req;
    int unsigned stalled_cycles;

    int unsigned fail_count;
    int unsigned pending_pairs;
    int unsigned samples_seen;
    int unsigned pairs_seen;

    alrle_in_if  sample_ch ();
    alrle_out_if pair_ch ();

    audio_level_run_length_encoder_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (sample_ch),
        .pairs       (pair_ch)
    );

    alrle_pair_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .samples       (sample_ch),
        .pairs         (pair_ch),
        .fail_count    (fail_count),
        .pending_pairs (pending_pairs),
        .samples_seen  (samples_seen),
        .pairs_seen    (pairs_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = '0;
        sample_ch.valid       = 1'b0;
        sample_ch.sample      = '0;
        sample_ch.last_sample = 1'b0;
        pair_ch.ready         = 1'b0;
        hold_rx               = 1'b0;
        hold_req              = 1'b0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        stalled_cycles        = 0;
    end

    always @(posedge clk)
        pair_ch.ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);

    // Long receiver hold-off so the burst queue fills and the input stalls
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (pair_ch.valid && pair_ch.ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [15:0] smp, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.sample      <= smp;
        sample_ch.last_sample <= lst;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid, wait for every predicted pair, then let the pipeline settle
    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_pairs != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly runs of one sample value (sometimes jittered), some lone noise beats
    task automatic send_runs(input int n_items);
        int                 sent;
        int                 sel;
        int                 len;
        logic               jitter;
        logic signed [15:0] base;
        sent = 0;
        while (sent < n_items)
        begin
            sel  = $urandom_range(99);
            base = 16'($urandom);
            if (sel < 12)
            begin
                send_sample(base, $urandom_range(7) == 0);
                sent++;
            end
            else
            begin
                len = $urandom_range(12, 1);
                if (len > n_items - sent)
                    len = n_items - sent;
                jitter = 1'($urandom_range(1));
                for (int k = 0; k < len; k++)
                    send_sample(jitter ? base + 16'($urandom_range(40)) : base,
                                (k == len - 1) && ($urandom_range(2) == 0));
                sent += len;
            end
        end
    endtask

    initial
    begin
        int lim;
        send_idle_pct  = 29;
        recv_stall_pct = 60;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Level extremes and bucket edges at the reset limit
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd32767, 1'b1);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd257, 1'b1);
        send_sample(16'sd258, 1'b0);
        send_sample(-16'sd258, 1'b0);
        send_sample(-16'sd259, 1'b1);
        // Level change and flush on one beat: two pairs
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd30000, 1'b1);

        // Split at the limit, then a change with nothing pending
        write_limit(8'd3);
        send_sample(16'sd1000, 1'b0);
        send_sample(16'sd1000, 1'b0);
        send_sample(16'sd1000, 1'b0);
        send_sample(16'sd2000, 1'b0);
        send_sample(16'sd2000, 1'b1);

        // Limit zero behaves as one
        write_limit(8'd0);
        send_sample(-16'sd5000, 1'b0);
        send_sample(-16'sd5000, 1'b0);
        send_sample(16'sd7000, 1'b1);

        // Lower the limit below a chunk already open
        write_limit(8'd255);
        repeat (5) send_sample(16'sd600, 1'b0);
        write_limit(8'd2);
        send_sample(16'sd600, 1'b0);
        send_sample(16'sd600, 1'b1);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 29; recv_stall_pct = 60; end
                1:       begin send_idle_pct = 60; recv_stall_pct = 29; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            for (int blk = 0; blk < 3; blk++)
            begin
                case ($urandom_range(4))
                    0:       lim = 1;
                    1:       lim = 255;
                    2:       lim = $urandom_range(8, 2);
                    3:       lim = $urandom_range(254, 9);
                    default: lim = 0;
                endcase
                if (ph == 0 && blk == 0)
                    lim = 1;
                write_limit(8'(lim));
                if (ph == 0 && blk == 0)
                    hold_req = 1'b1;
                send_runs(BLOCK_ITEMS);
            end
        end

        // One run long enough to split at the widest chunk
        write_limit(8'd255);
        repeat (LONG_RUN_ITEMS - 1) send_sample(16'sd12345, 1'b0);
        send_sample(16'sd12345, 1'b1);

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        $display("Encoded %0d samples into %0d pairs at limits 0, 1, 2, 3, 255 and random ones,",
                 samples_seen, pairs_seen);
        $display("under three idle mixes, a long receiver hold-off and a run split at 255.");
        if (fail_count == 0 && pending_pairs == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
